[design/command_retry_timeout_tracker_assert.svh]
// assertion macros for the command retry timeout tracker
`ifndef COMMAND_RETRY_TIMEOUT_TRACKER_ASSERT_SVH
`define COMMAND_RETRY_TIMEOUT_TRACKER_ASSERT_SVH
// implication checked on every clock edge outside reset
`define CRTT_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// implication checked on the clock edge after the premise
`define CRTT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

[design/crtt_pkg.sv]
// shared types and constants of the command retry timeout tracker
package crtt_pkg;
  localparam int SeqBits  = 6;
  localparam int ArgBytes = 8;
  localparam int TimeBits = 32;
  localparam int NumSeq   = 1 << SeqBits;
  localparam int ArgW     = 64;
  localparam int LenW     = 4;

  localparam logic [1:0] OpTrackNext = 2'd0;
  localparam logic [1:0] OpTrackSeq  = 2'd1;
  localparam logic [1:0] OpAck       = 2'd2;
  localparam logic [1:0] OpTick      = 2'd3;

  localparam logic [2:0] KindIssued  = 3'd0;
  localparam logic [2:0] KindAckHit  = 3'd1;
  localparam logic [2:0] KindAckMiss = 3'd2;
  localparam logic [2:0] KindResend  = 3'd3;
  localparam logic [2:0] KindFailed  = 3'd4;

  localparam logic [0:0] CfgTimeout = 1'd0;
  localparam logic [0:0] CfgRetry   = 1'd1;

  // one table entry without its valid mark
  typedef struct packed {
    logic [7:0]          ctype;
    logic [ArgW-1:0]     arg;
    logic [LenW-1:0]     len;
    logic [TimeBits-1:0] sent;
    logic [7:0]          retries;
  } entry_t;

  // memory access from the sequencer
  typedef struct packed {
    logic               rd_en;
    logic [SeqBits-1:0] rd_addr;
    logic               wr_en;
    logic [SeqBits-1:0] wr_addr;
    entry_t             wr_data;
  } mem_req_t;
endpackage

[design/crtt_entry_ram.sv]
// entry table memory, one write and one registered read port
module crtt_entry_ram (
  input  logic                clk_i,
  input  crtt_pkg::mem_req_t  req_i,
  output crtt_pkg::entry_t    rd_data_o
);
  crtt_pkg::entry_t mem [crtt_pkg::NumSeq];

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_o <= mem[req_i.rd_addr];
    end
  end
endmodule

[design/command_retry_timeout_tracker.sv]
// Command retry timeout tracker. Track-next and ack words put their single
// result in the output register in the cycle after acceptance, and the next
// word is taken only when the output register is free. An explicit track
// gives no result and leaves the block idle for the next word. A tick with
// any valid entry walks all 64 entries through the entry memory, each one in
// a read state and then an eval state (compare and write back). One expired
// entry is held back so that the last flag can be set on the final result.
// That result leaves from a closing flush state; output stalls hold the walk.
// Valid marks sit in flip-flops and are cleared at reset, so no clearing pass
// is needed. Configuration is written through a plain write port and must
// only change while the block is idle.
module command_retry_timeout_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [5:0]  seq_in_i,
  input  logic [7:0]  cmd_type_in_i,
  input  logic [63:0] arg_data_in_i,
  input  logic [3:0]  arg_len_in_i,
  input  logic [31:0] now_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [5:0]  seq_out_o,
  output logic [7:0]  cmd_type_out_o,
  output logic [63:0] arg_data_out_o,
  output logic [3:0]  arg_len_out_o,
  output logic [7:0]  retry_count_out_o,
  output logic        last_o
);
  localparam int SB = crtt_pkg::SeqBits;
  localparam int TB = crtt_pkg::TimeBits;

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_EVAL, ST_EMIT, ST_FLUSH} state_e;

  state_e                state_q;
  logic [31:0]           timeout_q;
  logic [7:0]            limit_q;
  logic [crtt_pkg::NumSeq-1:0] valid_q;
  logic [SB-1:0]         next_seq_q;
  logic [SB:0]           idx_q;
  logic [1:0]            op_q;
  logic [SB-1:0]         seq_q;
  logic [TB-1:0]         now_q;
  logic                  pend_q;
  logic                  hold_q;
  logic [2:0]            hold_kind_q;
  logic [SB-1:0]         hold_seq_q;
  logic [7:0]            hold_ctype_q;
  logic [63:0]           hold_arg_q;
  logic [3:0]            hold_len_q;
  logic [7:0]            hold_retries_q;
  crtt_pkg::mem_req_t    req;
  crtt_pkg::entry_t      rd_data;
  crtt_pkg::entry_t      new_entry;
  logic [TB-1:0]         age;
  logic                  expired;
  logic                  can_retry;
  logic                  out_free;
  logic                  out_load;
  logic [SB-1:0]         cur;
  logic [3:0]            len_sat;
  logic [63:0]           arg_mask;

  crtt_entry_ram u_ram (.clk_i(clk_i), .req_i(req), .rd_data_o(rd_data));

  assign cur      = idx_q[SB-1:0];
  assign out_free = !out_valid_o || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;

  // a new word enters the output register
  assign out_load = out_free && ((state_q == ST_EMIT) ||
                                 (state_q == ST_EVAL && expired && hold_q) ||
                                 (state_q == ST_FLUSH && hold_q));

  // argument length saturation and byte masking
  always_comb begin
    len_sat = (arg_len_in_i > 4'(crtt_pkg::ArgBytes)) ? 4'(crtt_pkg::ArgBytes)
                                                     : arg_len_in_i;
    for (int b = 0; b < 8; b++) begin
      arg_mask[b*8 +: 8] = (4'(b) < len_sat) ? 8'hFF : 8'h00;
    end
    new_entry.ctype   = cmd_type_in_i;
    new_entry.arg     = arg_data_in_i & arg_mask;
    new_entry.len     = len_sat;
    new_entry.sent    = now_time_i[TB-1:0];
    new_entry.retries = 8'd0;
  end

  // expiry decision on the read entry
  assign age       = now_q - rd_data.sent;
  assign expired   = valid_q[cur] && ({32'd0, age} >= {{TB{1'b0}}, timeout_q});
  assign can_retry = rd_data.retries < limit_q;

  // memory requests
  always_comb begin
    req = '0;
    req.rd_addr = cur;
    req.wr_addr = cur;
    req.wr_data = rd_data;
    if (state_q == ST_IDLE && in_valid_i && in_ready_o &&
        (opcode_i == crtt_pkg::OpTrackNext || opcode_i == crtt_pkg::OpTrackSeq)) begin
      req.wr_en   = 1'b1;
      req.wr_addr = (opcode_i == crtt_pkg::OpTrackNext) ? next_seq_q : seq_in_i;
      req.wr_data = new_entry;
    end else if (state_q == ST_READ) begin
      req.rd_en = 1'b1;
    end else if (state_q == ST_EVAL && out_free && expired && can_retry) begin
      req.wr_en           = 1'b1;
      req.wr_data.retries = rd_data.retries + 8'd1;
      req.wr_data.sent    = now_q;
    end
  end

  // control, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      timeout_q   <= 32'd1000;
      limit_q     <= 8'd3;
      valid_q     <= '0;
      next_seq_q  <= '0;
      idx_q       <= '0;
      op_q        <= crtt_pkg::OpTrackNext;
      seq_q       <= '0;
      now_q       <= '0;
      pend_q      <= 1'b0;
      hold_q         <= 1'b0;
      hold_kind_q    <= '0;
      hold_seq_q     <= '0;
      hold_ctype_q   <= '0;
      hold_arg_q     <= '0;
      hold_len_q     <= '0;
      hold_retries_q <= '0;
      out_valid_o <= 1'b0;
      kind_o            <= '0;
      seq_out_o         <= '0;
      cmd_type_out_o    <= '0;
      arg_data_out_o    <= '0;
      arg_len_out_o     <= '0;
      retry_count_out_o <= '0;
      last_o            <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          crtt_pkg::CfgTimeout: timeout_q <= cfg_wdata_i;
          crtt_pkg::CfgRetry:   limit_q   <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            op_q  <= opcode_i;
            now_q <= now_time_i[TB-1:0];
            idx_q <= '0;
            case (opcode_i)
              crtt_pkg::OpTrackNext: begin
                valid_q[next_seq_q] <= 1'b1;
                seq_q      <= next_seq_q;
                next_seq_q <= next_seq_q + 1'b1;
                state_q    <= ST_EMIT;
              end
              crtt_pkg::OpTrackSeq: valid_q[seq_in_i] <= 1'b1;
              crtt_pkg::OpAck: begin
                seq_q   <= seq_in_i;
                pend_q  <= valid_q[seq_in_i];
                valid_q[seq_in_i] <= 1'b0;
                state_q <= ST_EMIT;
              end
              default: state_q <= (|valid_q) ? ST_READ : ST_IDLE;
            endcase
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            kind_o            <= (op_q == crtt_pkg::OpTrackNext) ? crtt_pkg::KindIssued :
                                 pend_q ? crtt_pkg::KindAckHit : crtt_pkg::KindAckMiss;
            seq_out_o         <= seq_q;
            cmd_type_out_o    <= '0;
            arg_data_out_o    <= '0;
            arg_len_out_o     <= '0;
            retry_count_out_o <= '0;
            last_o            <= 1'b1;
            state_q           <= ST_IDLE;
          end
        end
        ST_READ: state_q <= ST_EVAL;
        ST_EVAL: begin
          if (out_free) begin
            if (expired) begin
              // a further result follows, so the held one is not the last
              if (hold_q) begin
                kind_o            <= hold_kind_q;
                seq_out_o         <= hold_seq_q;
                cmd_type_out_o    <= hold_ctype_q;
                arg_data_out_o    <= hold_arg_q;
                arg_len_out_o     <= hold_len_q;
                retry_count_out_o <= hold_retries_q;
                last_o            <= 1'b0;
              end
              hold_q       <= 1'b1;
              hold_seq_q   <= cur;
              hold_ctype_q <= rd_data.ctype;
              if (can_retry) begin
                hold_kind_q    <= crtt_pkg::KindResend;
                hold_arg_q     <= rd_data.arg;
                hold_len_q     <= rd_data.len;
                hold_retries_q <= rd_data.retries + 8'd1;
              end else begin
                hold_kind_q    <= crtt_pkg::KindFailed;
                hold_arg_q     <= '0;
                hold_len_q     <= '0;
                hold_retries_q <= '0;
                valid_q[cur]   <= 1'b0;
              end
            end
            idx_q   <= idx_q + 1'b1;
            state_q <= (idx_q == (SB+1)'(crtt_pkg::NumSeq - 1)) ? ST_FLUSH : ST_READ;
          end
        end
        // final result of the scan carries last
        ST_FLUSH: begin
          if (!hold_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            kind_o            <= hold_kind_q;
            seq_out_o         <= hold_seq_q;
            cmd_type_out_o    <= hold_ctype_q;
            arg_data_out_o    <= hold_arg_q;
            arg_len_out_o     <= hold_len_q;
            retry_count_out_o <= hold_retries_q;
            last_o            <= 1'b1;
            hold_q            <= 1'b0;
            state_q           <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

[design/crtt_checker.sv]
// port-level checks of the command retry timeout tracker
`include "command_retry_timeout_tracker_assert.svh"
module crtt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] opcode_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] kind_o,
  input logic       last_o
);
  `CRTT_ASSERT_IMP(a_kind_range, clk_i, rst_ni, out_valid_o, kind_o <= crtt_pkg::KindFailed, "kind out of range")
  `CRTT_ASSERT_IMP(a_single_last, clk_i, rst_ni, out_valid_o && (kind_o <= crtt_pkg::KindAckMiss), last_o, "single result without last")
  `CRTT_ASSERT_NEXT(a_no_take_busy, clk_i, rst_ni, in_valid_i && in_ready_o && (opcode_i == crtt_pkg::OpTrackNext || opcode_i == crtt_pkg::OpAck), !in_ready_o, "input taken while busy")
  `CRTT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(kind_o), "stalled result changed")
endmodule

bind command_retry_timeout_tracker crtt_checker u_crtt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .opcode_i(opcode_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .kind_o(kind_o), .last_o(last_o)
);

[tb/tb_command_retry_timeout_tracker.sv]
// self-checking testbench for the command retry timeout tracker
module tb_command_retry_timeout_tracker;

  // one input word
  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  seq;
    logic [7:0]  ctype;
    logic [63:0] arg;
    logic [3:0]  len;
    logic [31:0] now;
  } cmd_word_t;

  // one result word
  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  seq;
    logic [7:0]  ctype;
    logic [63:0] arg;
    logic [3:0]  len;
    logic [7:0]  retries;
    logic        last;
  } event_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = crtt_pkg::CfgTimeout;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i = crtt_pkg::OpTick;
  logic [5:0]  seq_in_i = '0;
  logic [7:0]  cmd_type_in_i = '0;
  logic [63:0] arg_data_in_i = '0;
  logic [3:0]  arg_len_in_i = '0;
  logic [31:0] now_time_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  kind_o;
  logic [5:0]  seq_out_o;
  logic [7:0]  cmd_type_out_o;
  logic [63:0] arg_data_out_o;
  logic [3:0]  arg_len_out_o;
  logic [7:0]  retry_count_out_o;
  logic        last_o;

  command_retry_timeout_tracker i_dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [31:0]       mdl_timeout;
  logic [7:0]        mdl_retry_limit;
  logic              tbl_valid [crtt_pkg::NumSeq];
  crtt_pkg::entry_t  tbl_entry [crtt_pkg::NumSeq];
  logic [5:0]        tbl_next;

  cmd_word_t   pending_words[$];
  event_word_t expected_events[$];
  int          errors = 0;
  int          cycles = 0;
  bit          send_hold = 1'b0;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic event_word_t mk_event(logic [2:0] k, logic [5:0] s);
    event_word_t e;
    e = '0;
    e.kind = k;
    e.seq  = s;
    return e;
  endfunction

  function automatic void store_cmd(logic [5:0] s, cmd_word_t w);
    logic [3:0]  l;
    logic [63:0] a;
    l = (w.len > crtt_pkg::ArgBytes) ? 4'(crtt_pkg::ArgBytes) : w.len;
    a = w.arg;
    if (l < 8) a &= (64'd1 << (l * 8)) - 64'd1;
    tbl_valid[s] = 1'b1;
    tbl_entry[s] = '{ctype: w.ctype, arg: a, len: l, sent: w.now, retries: 8'd0};
  endfunction

  // work out the events one accepted word causes
  function automatic void predict_events(cmd_word_t w);
    int first;
    logic [31:0] age;
    event_word_t e;
    first = expected_events.size();
    case (w.op)
      crtt_pkg::OpTrackNext: begin
        expected_events = {expected_events, mk_event(crtt_pkg::KindIssued, tbl_next)};
        store_cmd(tbl_next, w);
        tbl_next++;
      end
      crtt_pkg::OpTrackSeq: store_cmd(w.seq, w);
      crtt_pkg::OpAck: begin
        expected_events = {expected_events,
                           mk_event(tbl_valid[w.seq] ? crtt_pkg::KindAckHit
                                                     : crtt_pkg::KindAckMiss, w.seq)};
        tbl_valid[w.seq] = 1'b0;
      end
      default: begin
        for (int s = 0; s < crtt_pkg::NumSeq; s++) begin
          if (!tbl_valid[s]) continue;
          age = w.now - tbl_entry[s].sent;
          if (age < mdl_timeout) continue;
          e = mk_event(crtt_pkg::KindFailed, 6'(s));
          e.ctype = tbl_entry[s].ctype;
          if (tbl_entry[s].retries < mdl_retry_limit) begin
            tbl_entry[s].retries++;
            tbl_entry[s].sent = w.now;
            e.kind = crtt_pkg::KindResend;
            e.arg = tbl_entry[s].arg;
            e.len = tbl_entry[s].len;
            e.retries = tbl_entry[s].retries;
          end else begin
            tbl_valid[s] = 1'b0;
          end
          expected_events = {expected_events, e};
        end
      end
    endcase
    if (expected_events.size() > first)
      expected_events[expected_events.size()-1].last = 1'b1;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (in_valid_i && in_ready_o) predict_events({opcode_i, seq_in_i, cmd_type_in_i,
                                                  arg_data_in_i, arg_len_in_i, now_time_i});
    if (!in_valid_i || in_ready_o) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() > 0 && !send_hold) begin
        {opcode_i, seq_in_i, cmd_type_in_i, arg_data_in_i, arg_len_in_i, now_time_i}
          <= pending_words.pop_front();
        in_valid_i <= 1'b1;
        in_gap <= gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor with random output stalls
  int out_gap = 0;
  always @(posedge clk_i) begin
    event_word_t got, want;
    if (out_valid_o && out_ready_i) begin
      got = {kind_o, seq_out_o, cmd_type_out_o, arg_data_out_o, arg_len_out_o,
             retry_count_out_o, last_o};
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event kind %0d seq %0d", kind_o, seq_out_o));
      end else begin
        want = expected_events.pop_front();
        if (got.kind != want.kind)
          report_mismatch($sformatf("kind %0d want %0d", got.kind, want.kind));
        if (got.seq != want.seq)
          report_mismatch($sformatf("seq %0d want %0d", got.seq, want.seq));
        if (got.ctype != want.ctype)
          report_mismatch($sformatf("cmd type %h want %h", got.ctype, want.ctype));
        if (got.arg != want.arg)
          report_mismatch($sformatf("arg %h want %h", got.arg, want.arg));
        if (got.len != want.len)
          report_mismatch($sformatf("arg len %0d want %0d", got.len, want.len));
        if (got.retries != want.retries)
          report_mismatch($sformatf("retries %0d want %0d", got.retries, want.retries));
        if (got.last != want.last)
          report_mismatch($sformatf("last %0d want %0d", got.last, want.last));
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!out_ready_i || $urandom_range(0, 3) == 0) out_gap <= gap_len();
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    if (cycles > 900000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic cmd_word_t mk_word(logic [1:0] op, logic [5:0] s, logic [31:0] t);
    cmd_word_t w;
    w.op = op;
    w.seq = s;
    w.ctype = 8'($urandom);
    w.arg = {$urandom, $urandom};
    w.len = 4'($urandom_range(0, 15));
    w.now = t;
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid_i || expected_events.size() > 0)
      @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == crtt_pkg::CfgTimeout) mdl_timeout = val;
    else mdl_retry_limit = val[7:0];
  endtask

  // random well-formed traffic: tracks, acks and ticks at advancing time
  task automatic random_phase(int n, int step_max, ref logic [31:0] t);
    cmd_word_t w;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      t += $urandom_range(0, step_max);
      if (r < 3)      w = mk_word(crtt_pkg::OpTrackNext, 6'($urandom), t);
      else if (r < 5) w = mk_word(crtt_pkg::OpTrackSeq, 6'($urandom), t);
      else if (r < 7) w = mk_word(crtt_pkg::OpAck, 6'($urandom), t);
      else            w = mk_word(crtt_pkg::OpTick, 6'($urandom), t);
      if (w.op != crtt_pkg::OpTick && $urandom_range(0, 4) == 0)
        w.len = 4'($urandom_range(9, 15));
      pending_words = {pending_words, w};
    end
  endtask

  initial begin
    logic [31:0] t;
    cmd_word_t w;
    mdl_timeout = 32'd1000;
    mdl_retry_limit = 8'd3;
    tbl_next = '0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    foreach (tbl_entry[i]) tbl_entry[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, each operation, wrap of time, over-long args
    w = mk_word(crtt_pkg::OpTrackNext, 6'd0, 32'hFFFF_FF00);
    w.arg = '1; w.len = 4'd15; w.ctype = 8'hFF;
    pending_words = {pending_words, w};
    w = mk_word(crtt_pkg::OpTrackSeq, 6'd63, 32'd0);
    w.arg = '1; w.len = 4'd0; w.ctype = 8'h00;
    pending_words = {pending_words, w};
    w = mk_word(crtt_pkg::OpTrackSeq, 6'd5, 32'd10); w.len = 4'd8;
    pending_words = {pending_words, w};
    w = mk_word(crtt_pkg::OpTrackSeq, 6'd5, 32'd20); w.len = 4'd3;
    pending_words = {pending_words, w};
    pending_words = {pending_words, mk_word(crtt_pkg::OpAck, 6'd63, 32'd0)};
    pending_words = {pending_words, mk_word(crtt_pkg::OpAck, 6'd63, 32'd0)};
    pending_words = {pending_words, mk_word(crtt_pkg::OpTick, 6'd0, 32'd100)};
    for (int k = 0; k < 5; k++)
      pending_words = {pending_words,
                       mk_word(crtt_pkg::OpTick, 6'd0, 32'd2000 + 32'd1000 * k)};
    pending_words = {pending_words, mk_word(crtt_pkg::OpTick, 6'd0, 32'hFFFF_FFFF)};
    t = 32'd50000;
    wait_drained();

    // zero-retry limit and zero timeout
    write_reg(crtt_pkg::CfgRetry, 32'd0);
    write_reg(crtt_pkg::CfgTimeout, 32'd0);
    for (int k = 0; k < 66; k++)
      pending_words = {pending_words, mk_word(crtt_pkg::OpTrackNext, 6'd0, t)};
    pending_words = {pending_words, mk_word(crtt_pkg::OpTick, 6'd0, t)};
    wait_drained();

    write_reg(crtt_pkg::CfgRetry, 32'd255);
    write_reg(crtt_pkg::CfgTimeout, 32'd1);
    random_phase(80, 3, t);
    wait_drained();

    // hold the sender until every event is in
    write_reg(crtt_pkg::CfgRetry, 32'd2);
    write_reg(crtt_pkg::CfgTimeout, 32'd40);
    random_phase(40, 30, t);
    while (pending_words.size() > 0 || in_valid_i)
      @(posedge clk_i);
    send_hold = 1'b1;
    random_phase(40, 30, t);
    while (expected_events.size() > 0)
      @(posedge clk_i);
    send_hold = 1'b0;
    wait_drained();

    write_reg(crtt_pkg::CfgTimeout, 32'hFFFF_FFFF);
    write_reg(crtt_pkg::CfgRetry, 32'd3);
    random_phase(30, 32'h7FFF_FFFF, t);
    wait_drained();

    write_reg(crtt_pkg::CfgTimeout, 32'd1000);
    random_phase(40, 400, t);
    wait_drained();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
